// ===== hdl/lei_pkg.sv =====
// ----------------------------------------------------------------------------
// lei_pkg: shared types and constants for the Langevin integrator step
// Widths, register indexes, the divider request and status structs and a shift helper.
// ----------------------------------------------------------------------------
package lei_pkg;

  localparam int unsigned Dimensions = 3;
  localparam int unsigned MaxAtoms   = 65536;
  localparam int unsigned CountW     = 17;

  // configuration register indexes
  localparam logic [2:0] RegDecay    = 3'd0;
  localparam logic [2:0] RegVelStep  = 3'd1;
  localparam logic [2:0] RegForcePos = 3'd2;
  localparam logic [2:0] RegPosSigma = 3'd3;
  localparam logic [2:0] RegVelSigma = 3'd4;

  // divider request / status
  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [63:0] den;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [63:0] quo;
  } div_rsp_t;

  // floor(x / 65536) for a signed product
  function automatic logic signed [65:0] fshift16(input logic signed [81:0] x);
    fshift16 = 66'(x >>> 16);
  endfunction

endpackage

// ===== hdl/lei_divider.sv =====
// ----------------------------------------------------------------------------
// lei_divider: unsigned 64/64 radix-2 restoring divider
// One quotient bit per cycle.
// ----------------------------------------------------------------------------
module lei_divider (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lei_pkg::div_req_t req_i,
  output lei_pkg::div_rsp_t rsp_o
);

  logic [63:0] rem_q, rem_d, quo_q, quo_d, den_q, den_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [64:0] trial;

  // one shift-subtract step
  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, quo_q[63]} - {1'b0, den_q};
    if (req_i.start) begin
      rem_d  = '0;
      quo_d  = req_i.num;
      den_d  = req_i.den;
      cnt_d  = 7'd0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[64]) begin
        rem_d = trial[63:0];
        quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = {rem_q[62:0], quo_q[63]};
        quo_d = {quo_q[62:0], 1'b0};
      end
      cnt_d = cnt_q + 7'd1;
      if (cnt_q == 7'd63) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

  // a done pulse only ends a running request
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_q |-> $past(busy_q))
    else $error("divider done without busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !req_i.start) |=> (cnt_q == $past(cnt_q) + 7'd1) || !busy_q)
    else $error("divider step count skipped");
  assert property (@(posedge clk_i) disable iff (!rst_ni) !busy_q |-> !done_d)
    else $error("divider finished while idle");

endmodule

// ===== hdl/langevin_ermak_integrator_step.sv =====
// ----------------------------------------------------------------------------
// langevin_ermak_integrator_step: Langevin integrator, one component per item
// A sequencer drives one multiplier and one divider over several steps.
// ----------------------------------------------------------------------------
// channel | direction | handshake
// in      | request   | in_valid_i / in_stall_o
// out     | result    | out_valid_o / out_stall_i
// cfg     | write     | cfg_we_i, cfg_idx_i, cfg_data_i
// A free item: a start state, the acceleration division, 6 multiply steps,
// 1 accumulate step and an output state that holds the result until taken.
// Sweep end adds the temperature division (skipped when the count is at
// most one); a fixed item skips the acceleration division and multiply steps.
// Reset clears control, counters, the square sum and loads the reset coeffs.
// A held result stalls the block; the next request waits until it is taken.
// ----------------------------------------------------------------------------
module langevin_ermak_integrator_step (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [30:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] position_i,
  input  logic signed [31:0] velocity_i,
  input  logic signed [31:0] force_req_i,
  input  logic [30:0]        mass_i,
  input  logic signed [31:0] unit_noise_position_i,
  input  logic signed [31:0] unit_noise_velocity_i,
  input  logic               is_free_i,
  input  logic               last_component_i,
  input  logic               last_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] new_position_o,
  output logic signed [31:0] new_velocity_o,
  output logic [62:0]        kinetic_energy_o,
  output logic [62:0]        temperature_o,
  output logic               sweep_done_o,
  output logic               temperature_invalid_o
);

  typedef enum logic [7:0] {
    StIdle  = 8'b0000_0001,
    StDivA  = 8'b0000_0010,
    StWaitA = 8'b0000_0100,
    StMul   = 8'b0000_1000,
    StAcc   = 8'b0001_0000,
    StDivT  = 8'b0010_0000,
    StWaitT = 8'b0100_0000,
    StOut   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  // coefficients
  logic [16:0] c0_q;
  logic [30:0] c1_q, c2_q, sr_q, sv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c0_q <= 17'd65536;
      c1_q <= '0;
      c2_q <= '0;
      sr_q <= '0;
      sv_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lei_pkg::RegDecay:    c0_q <= cfg_data_i[16:0];
        lei_pkg::RegVelStep:  c1_q <= cfg_data_i;
        lei_pkg::RegForcePos: c2_q <= cfg_data_i;
        lei_pkg::RegPosSigma: sr_q <= cfg_data_i;
        lei_pkg::RegVelSigma: sv_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // captured request
  logic signed [31:0] r_q, v_q, gr_q, gv_q, a_q;
  logic [30:0]        m_q;
  logic               neg_q, free_q, lastc_q, last_q;
  logic [63:0]        mag_in;
  logic [63:0]        fmag_q;

  // accumulators
  logic signed [49:0] pos_acc_q, pos_acc_d, vel_acc_q, vel_acc_d;
  logic [2:0]         mstep_q, mstep_d;
  logic [63:0]        sum_q, sum_d;
  logic [lei_pkg::CountW-1:0] cnt_q, cnt_d;

  // output register
  logic signed [31:0] npos_q, nvel_q;
  logic [62:0]        ke_q, temp_q;
  logic               done_q, inval_q;

  // divider
  lei_pkg::div_req_t div_req;
  lei_pkg::div_rsp_t div_rsp;
  lei_divider u_div (.clk_i, .rst_ni, .req_i(div_req), .rsp_o(div_rsp));

  // shared multiplier: coefficient times signed operand
  logic [30:0]        mul_c;
  logic signed [31:0] mul_v;
  logic signed [65:0] mul_p;
  always_comb begin
    unique case (mstep_q)
      3'd0:    begin mul_c = c1_q;          mul_v = v_q;  end
      3'd1:    begin mul_c = c2_q;          mul_v = a_q;  end
      3'd2:    begin mul_c = sr_q;          mul_v = gr_q; end
      3'd3:    begin mul_c = {14'd0, c0_q}; mul_v = v_q;  end
      3'd4:    begin mul_c = c1_q;          mul_v = a_q;  end
      default: begin mul_c = sv_q;          mul_v = gv_q; end
    endcase
    mul_p = lei_pkg::fshift16(82'($signed({1'b0, mul_c})) * 82'(mul_v));
  end

  function automatic logic signed [31:0] sat32(input logic signed [49:0] x);
    if (x > 50'sd2147483647)       sat32 = 32'sh7fffffff;
    else if (x < -50'sd2147483648) sat32 = 32'sh80000000;
    else                           sat32 = x[31:0];
  endfunction

  logic signed [31:0] nv_sat;
  logic [31:0]        nv_mag;
  logic [63:0]        nv_sq;
  logic [64:0]        sum_ext;
  logic [63:0]        quo;
  logic [lei_pkg::CountW+1:0] den3;

  assign nv_sat  = sat32(vel_acc_q);
  assign nv_mag  = nv_sat[31] ? 32'(-nv_sat) : 32'(nv_sat);
  assign nv_sq   = 64'(nv_mag) * 64'(nv_mag);
  assign sum_ext = 65'(sum_q) + 65'(nv_sq);
  assign quo     = div_rsp.quo;
  assign den3    = (lei_pkg::CountW+2)'(lei_pkg::Dimensions)
                   * (lei_pkg::CountW+2)'(cnt_q - (lei_pkg::CountW)'(1));
  assign mag_in  = force_req_i[31] ? 64'(-{{16{force_req_i[31]}}, force_req_i, 16'd0})
                                   : {16'd0, force_req_i, 16'd0};

  logic in_acc;
  assign in_stall_o  = (state_q != StIdle);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = (state_q == StOut);

  // sequencer
  always_comb begin
    state_d   = state_q;
    mstep_d   = mstep_q;
    pos_acc_d = pos_acc_q;
    vel_acc_d = vel_acc_q;
    sum_d     = sum_q;
    cnt_d     = cnt_q;
    // acceleration numerator comes from the stored force magnitude
    div_req   = '{start: 1'b0, num: fmag_q, den: 64'(m_q)};
    unique case (state_q)
      StIdle: if (in_acc) state_d = is_free_i ? StDivA : (last_item_i ? StDivT : StOut);
      StDivA: begin
        div_req.start = 1'b1;
        state_d       = StWaitA;
      end
      StWaitA: if (div_rsp.done) begin
        mstep_d   = 3'd0;
        pos_acc_d = 50'(r_q);
        vel_acc_d = '0;
        state_d   = StMul;
      end
      StMul: begin
        if (mstep_q < 3'd3) pos_acc_d = pos_acc_q + 50'(mul_p);
        else                vel_acc_d = vel_acc_q + 50'(mul_p);
        mstep_d = mstep_q + 3'd1;
        if (mstep_q == 3'd5) state_d = StAcc;
      end
      StAcc: begin
        sum_d = sum_ext[64] ? '1 : sum_ext[63:0];
        if (lastc_q && cnt_q < (lei_pkg::CountW)'(lei_pkg::MaxAtoms)) begin
          cnt_d = cnt_q + (lei_pkg::CountW)'(1);
        end
        state_d = last_q ? StDivT : StOut;
      end
      StDivT: begin
        div_req.start = (cnt_q > 1);
        div_req.num   = sum_q;
        div_req.den   = 64'(den3);
        state_d       = (cnt_q > 1) ? StWaitT : StOut;
      end
      StWaitT: if (div_rsp.done) state_d = StOut;
      StOut: if (!out_stall_i) begin
        state_d = StIdle;
        // sweep end: clear the tally once the result is taken
        if (done_q) begin
          sum_d = '0;
          cnt_d = '0;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // acceleration: saturate the quotient with sign
  logic signed [31:0] accel;
  always_comb begin
    if (neg_q) accel = (quo > 64'h8000_0000) ? 32'sh80000000 : 32'(-quo[31:0]);
    else       accel = (quo > 64'h7fff_ffff) ? 32'sh7fffffff : quo[31:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      mstep_q <= '0;
      sum_q   <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      mstep_q <= mstep_d;
      sum_q   <= sum_d;
      cnt_q   <= cnt_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    pos_acc_q <= pos_acc_d;
    vel_acc_q <= vel_acc_d;
    if (in_acc) begin
      r_q     <= position_i;
      v_q     <= velocity_i;
      gr_q    <= unit_noise_position_i;
      gv_q    <= unit_noise_velocity_i;
      m_q     <= (mass_i == '0) ? 31'd1 : mass_i;
      neg_q   <= force_req_i[31];
      fmag_q  <= mag_in;
      free_q  <= is_free_i;
      lastc_q <= last_component_i;
      last_q  <= last_item_i;
      npos_q  <= position_i;
      nvel_q  <= velocity_i;
      ke_q    <= '0;
      temp_q  <= '0;
      done_q  <= last_item_i;
      inval_q <= 1'b0;
    end
    if (state_q == StWaitA && div_rsp.done) a_q <= accel;
    if (state_q == StAcc) begin
      npos_q <= sat32(pos_acc_q);
      nvel_q <= nv_sat;
    end
    if (state_q == StDivT) begin
      ke_q    <= sum_q[63:1];
      inval_q <= !(cnt_q > 1);
    end
    if (state_q == StWaitT && div_rsp.done) temp_q <= quo[62:0];
  end

  assign new_position_o        = npos_q;
  assign new_velocity_o        = nvel_q;
  assign kinetic_energy_o      = ke_q;
  assign temperature_o         = temp_q;
  assign sweep_done_o          = done_q;
  assign temperature_invalid_o = inval_q;

  // the divider runs only while the sequencer waits on it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.busy |-> (state_q == StWaitA || state_q == StWaitT))
    else $error("divider busy outside a wait state");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StOut && !out_stall_i && done_q) |=> (sum_q == '0 && cnt_q == '0))
    else $error("sweep state not cleared");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !done_q) |-> !inval_q)
    else $error("invalid flag off sweep end");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StMul) |-> free_q)
    else $error("fixed particle reached the multiplier");

endmodule
